@@ hdl/glyph_bitmap_expander_2x_core_defines.svh @@
// Assertion macros for the glyph expander core.
`ifndef GLYPH_BITMAP_EXPANDER_2X_CORE_DEFINES_SVH
`define GLYPH_BITMAP_EXPANDER_2X_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define GBE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define GBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gbe_pkg.sv @@
`default_nettype none

package gbe_pkg;

    // Input opcodes
    localparam logic OP_GLYPH_START = 1'b0;
    localparam logic OP_BITMAP_BYTE = 1'b1;

    // Configuration register indexes and reset values
    localparam int unsigned APB_ADDR_W = 4;
    localparam logic [1:0] REG_LINE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_LINE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEFT_MARGIN = 2'd2;
    localparam logic [11:0] LINE_WIDTH_RST  = 12'd300;
    localparam logic [7:0]  LINE_HEIGHT_RST = 8'd30;
    localparam logic [7:0]  LEFT_MARGIN_RST = 8'd10;

    // Cursor divider: one quotient bit per cycle
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Result queue in the expander
    localparam int unsigned OFIFO_DEPTH = 2;
    localparam int unsigned OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int unsigned OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_MUL
    } fe_state_t;

    typedef enum logic {
        BE_IDLE,
        BE_EXPAND
    } be_state_t;

    // Classified command from front to back
    typedef struct packed {
        logic        opcode;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [7:0]  bits;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } cmd_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic        lit;
        logic        glyph_done;
        logic        last;
    } pix_t;

    typedef struct packed {
        logic busy;
    } fe_status_t;

endpackage

`default_nettype wire

@@ hdl/glyph_bitmap_expander_2x_core.sv @@
`default_nettype none

// 2x glyph bitmap expander. Push a glyph-start transaction (opcode 0, width,
// height), then the glyph's bitmap bytes (opcode 1), 1 bpp, MSB first, packed
// continuously across rows. Each bitmap bit inside the glyph yields four pixel
// transactions covering a 2x2 block at (origin + left_margin + 2*col,
// origin + 2*row), ordered top-left, top-right, bottom-left, bottom-right;
// glyph_done marks the glyph's final pixel and last marks the final pixel of
// each byte. Bits beyond the glyph, bytes with no glyph open and zero-sized
// glyphs produce nothing. A glyph start takes the current pen as its origin and
// advances a 32-bit cursor by 2 + 2*width; the new pen is the cursor split by
// line_width (0 reads as 1) through a one-bit-a-cycle divider and a 16x8
// multiply, so full stays high while both run after a glyph start is taken.
// A bitmap byte goes from the front into the command queue; the expander pops it
// from the command queue and emits its up to 32 pixels one pixel a cycle,
// stalling whenever the result queue is full. A glyph start only loads the
// expander's origin and size and emits nothing. While the expander runs, the front keeps
// taking transactions into a CMD_DEPTH-entry command queue (full also rises
// when that queue is full), and a two-entry result queue decouples the pop side.
// Registers (APB, 4-byte stride): 0 line_width (12b, 300), 1 line_height
// (8b, 30), 2 left_margin (8b, 10). Write them only while the core is idle.

`include "glyph_bitmap_expander_2x_core_defines.svh"

module glyph_bitmap_expander_2x_core
#(
    parameter int unsigned CMD_DEPTH = 4
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [gbe_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire                              push,
    output logic                             full,
    input  wire                              opcode,
    input  wire  [7:0]                       glyph_width,
    input  wire  [7:0]                       glyph_height,
    input  wire  [7:0]                       bitmap_byte,
    output logic                             empty,
    input  wire                              pop,
    output logic [15:0]                      pixel_x,
    output logic [15:0]                      pixel_y,
    output logic                             lit,
    output logic                             glyph_done,
    output logic                             last
);

    // Configuration registers
    logic [11:0] line_width_reg, line_width_next;
    logic [7:0]  line_height_reg, line_height_next;
    logic [7:0]  left_margin_reg, left_margin_next;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // Front to queue to back
    logic                cmd_push;
    gbe_pkg::cmd_t       cmd_in;
    gbe_pkg::cmd_t       cmd_out;
    logic                cmdq_full;
    logic                cmdq_empty;
    logic                cmd_pop;
    gbe_pkg::fe_status_t fe_status;
    gbe_pkg::pix_t       res;
    logic                start_taken;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        line_width_next  = line_width_reg;
        line_height_next = line_height_reg;
        left_margin_next = left_margin_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                gbe_pkg::REG_LINE_WIDTH:  line_width_next  = pwdata[11:0];
                gbe_pkg::REG_LINE_HEIGHT: line_height_next = pwdata[7:0];
                gbe_pkg::REG_LEFT_MARGIN: left_margin_next = pwdata[7:0];
                default:                  line_width_next  = line_width_reg;
            endcase
        end

        case (cfg_idx)
            gbe_pkg::REG_LINE_WIDTH:  prdata = {20'd0, line_width_reg};
            gbe_pkg::REG_LINE_HEIGHT: prdata = {24'd0, line_height_reg};
            gbe_pkg::REG_LEFT_MARGIN: prdata = {24'd0, left_margin_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= gbe_pkg::LINE_WIDTH_RST;
            line_height_reg <= gbe_pkg::LINE_HEIGHT_RST;
            left_margin_reg <= gbe_pkg::LEFT_MARGIN_RST;
        end
        else
        begin
            line_width_reg  <= line_width_next;
            line_height_reg <= line_height_next;
            left_margin_reg <= left_margin_next;
        end
    end

    // Front: takes transactions, tracks cursor and pen, tags bytes with origin
    gbe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .bitmap_byte  (bitmap_byte),
        .line_width   (line_width_reg),
        .line_height  (line_height_reg),
        .cmdq_full    (cmdq_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in),
        .status       (fe_status)
    );

    gbe_cmdq #(.DEPTH(CMD_DEPTH)) u_cmdq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .pop     (cmd_pop),
        .cmd_out (cmd_out),
        .full    (cmdq_full),
        .empty   (cmdq_empty)
    );

    // Back: expands bytes into 2x2 pixel blocks
    gbe_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (!cmdq_empty),
        .cmd         (cmd_out),
        .cmd_pop     (cmd_pop),
        .left_margin (left_margin_reg),
        .pop         (pop),
        .empty       (empty),
        .res         (res)
    );

    assign pixel_x    = res.pixel_x;
    assign pixel_y    = res.pixel_y;
    assign lit        = res.lit;
    assign glyph_done = res.glyph_done;
    assign last       = res.last;

    // Checks
    assign start_taken = push && !full && (opcode == gbe_pkg::OP_GLYPH_START);

    `GBE_ASSERT_NEXT(a_start_holds_off, start_taken, full, "glyph start did not hold off input")
    `GBE_ASSERT_IMPL(a_busy_means_full, fe_status.busy, full, "input open while pen update runs")
    `GBE_ASSERT_IMPL(a_done_ends_item, !empty && glyph_done, last, "glyph done without last")

endmodule

`default_nettype wire

@@ hdl/gbe_front.sv @@
`default_nettype none

module gbe_front
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  wire                 opcode,
    input  wire  [7:0]          glyph_width,
    input  wire  [7:0]          glyph_height,
    input  wire  [7:0]          bitmap_byte,
    input  wire  [11:0]         line_width,
    input  wire  [7:0]          line_height,
    input  wire                 cmdq_full,
    output logic                cmd_push,
    output gbe_pkg::cmd_t       cmd,
    output gbe_pkg::fe_status_t status
);

    gbe_pkg::fe_state_t state_reg, state_next;
    logic [31:0] cursor_reg, cursor_next;
    logic [15:0] pen_x_reg, pen_x_next;
    logic [15:0] pen_y_reg, pen_y_next;
    logic [31:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [gbe_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [11:0] lw_reg, lw_next;
    logic [7:0]  lh_reg, lh_next;

    logic        accept;
    logic [31:0] cursor_sum;
    logic [12:0] trial;
    logic [12:0] diff;
    logic        ge;
    logic [23:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gbe_pkg::FE_IDLE;
            cursor_reg <= '0;
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        lw_reg  <= lw_next;
        lh_reg  <= lh_next;
    end

    always_comb
    begin
        full   = (state_reg != gbe_pkg::FE_IDLE) || cmdq_full;
        accept = push && !full;
        status.busy = (state_reg != gbe_pkg::FE_IDLE);

        cmd.opcode   = opcode;
        cmd.width    = glyph_width;
        cmd.height   = glyph_height;
        cmd.bits     = bitmap_byte;
        cmd.origin_x = pen_x_reg;
        cmd.origin_y = pen_y_reg;
        cmd_push     = accept;

        cursor_sum = cursor_reg + 32'd2 + {23'd0, glyph_width, 1'b0};
        // restoring division step: shift next dividend bit into remainder
        trial = {rem_reg, quo_reg[31]};
        ge    = (trial >= {1'b0, lw_reg});
        diff  = trial - {1'b0, lw_reg};
        prod  = quo_reg[15:0] * lh_reg;

        state_next  = state_reg;
        cursor_next = cursor_reg;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        lw_next     = lw_reg;
        lh_next     = lh_reg;

        case (state_reg)
            gbe_pkg::FE_IDLE:
            begin
                if (accept && (opcode == gbe_pkg::OP_GLYPH_START))
                begin
                    cursor_next = cursor_sum;
                    quo_next    = cursor_sum;
                    rem_next    = '0;
                    cnt_next    = '0;
                    lw_next     = (line_width == 12'd0) ? 12'd1 : line_width;
                    lh_next     = line_height;
                    state_next  = gbe_pkg::FE_DIV;
                end
            end
            gbe_pkg::FE_DIV:
            begin
                quo_next = {quo_reg[30:0], ge};
                rem_next = ge ? diff[11:0] : trial[11:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gbe_pkg::DIV_LAST)
                begin
                    state_next = gbe_pkg::FE_MUL;
                end
            end
            gbe_pkg::FE_MUL:
            begin
                // only the low 16 bits of the row offset survive
                pen_x_next = {4'd0, rem_reg};
                pen_y_next = prod[15:0];
                state_next = gbe_pkg::FE_IDLE;
            end
            default:
            begin
                state_next = gbe_pkg::FE_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/gbe_cmdq.sv @@
`default_nettype none

module gbe_cmdq
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    input  gbe_pkg::cmd_t cmd_in,
    input  wire           pop,
    output gbe_pkg::cmd_t cmd_out,
    output logic          full,
    output logic          empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(DEPTH);

    gbe_pkg::cmd_t q_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        full    = (cnt_reg == CNT_MAX);
        empty   = (cnt_reg == '0);
        cmd_out = q_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && !empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gbe_back.sv @@
`default_nettype none

module gbe_back
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           cmd_valid,
    input  gbe_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  wire  [7:0]    left_margin,
    input  wire           pop,
    output logic          empty,
    output gbe_pkg::pix_t res
);

    localparam logic [gbe_pkg::OFIFO_CW-1:0] OCNT_MAX = gbe_pkg::OFIFO_CW'(gbe_pkg::OFIFO_DEPTH);
    localparam logic [gbe_pkg::OFIFO_AW-1:0] OPTR_LAST =
        gbe_pkg::OFIFO_AW'(gbe_pkg::OFIFO_DEPTH - 1);

    gbe_pkg::be_state_t state_reg, state_next;
    logic        active_reg, active_next;
    logic [15:0] ox_reg, ox_next;
    logic [15:0] oy_reg, oy_next;
    logic [7:0]  aw_reg, aw_next;
    logic [7:0]  ah_reg, ah_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  bit_reg, bit_next;
    logic [1:0]  sub_reg, sub_next;

    gbe_pkg::pix_t ofifo_reg [gbe_pkg::OFIFO_DEPTH];
    logic [gbe_pkg::OFIFO_AW-1:0] owr_reg, owr_next;
    logic [gbe_pkg::OFIFO_AW-1:0] ord_reg, ord_next;
    logic [gbe_pkg::OFIFO_CW-1:0] ocnt_reg, ocnt_next;

    gbe_pkg::pix_t wdata;
    logic          wr_en;
    logic          rd_en;
    logic          ofull;
    logic [8:0]    col_inc;
    logic [8:0]    row_inc;
    logic          col_wrap;
    logic          glyph_end;
    logic          item_end;

    always_comb
    begin
        ofull = (ocnt_reg == OCNT_MAX);
        empty = (ocnt_reg == '0);
        res   = ofifo_reg[ord_reg];
        rd_en = pop && !empty;

        col_inc   = {1'b0, col_reg} + 9'd1;
        row_inc   = {1'b0, row_reg} + 9'd1;
        col_wrap  = (col_inc >= {1'b0, aw_reg});
        glyph_end = col_wrap && (row_inc >= {1'b0, ah_reg});
        item_end  = glyph_end || (bit_reg == 3'd0);

        // 2x2 block: sub bit 0 steps x, sub bit 1 steps y
        wdata.pixel_x    = ox_reg + {8'd0, left_margin} + {7'd0, col_reg, 1'b0}
                         + {15'd0, sub_reg[0]};
        wdata.pixel_y    = oy_reg + {7'd0, row_reg, 1'b0} + {15'd0, sub_reg[1]};
        wdata.lit        = byte_reg[bit_reg];
        wdata.glyph_done = (sub_reg == 2'd3) && glyph_end;
        wdata.last       = (sub_reg == 2'd3) && item_end;

        state_next  = state_reg;
        active_next = active_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        aw_next     = aw_reg;
        ah_next     = ah_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        byte_next   = byte_reg;
        bit_next    = bit_reg;
        sub_next    = sub_reg;
        cmd_pop     = 1'b0;
        wr_en       = 1'b0;

        case (state_reg)
            gbe_pkg::BE_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    if (cmd.opcode == gbe_pkg::OP_GLYPH_START)
                    begin
                        // a new glyph drops whatever was left of the previous one
                        ox_next     = cmd.origin_x;
                        oy_next     = cmd.origin_y;
                        aw_next     = cmd.width;
                        ah_next     = cmd.height;
                        col_next    = '0;
                        row_next    = '0;
                        active_next = (cmd.width != 8'd0) && (cmd.height != 8'd0);
                    end
                    else if (active_reg)
                    begin
                        byte_next  = cmd.bits;
                        bit_next   = 3'd7;
                        sub_next   = 2'd0;
                        state_next = gbe_pkg::BE_EXPAND;
                    end
                end
            end
            gbe_pkg::BE_EXPAND:
            begin
                wr_en = !ofull;
                if (!ofull)
                begin
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd3)
                    begin
                        bit_next = bit_reg - 3'd1;
                        if (col_wrap)
                        begin
                            col_next = '0;
                            row_next = row_inc[7:0];
                        end
                        else
                        begin
                            col_next = col_inc[7:0];
                        end
                        if (glyph_end)
                        begin
                            active_next = 1'b0;
                        end
                        if (item_end)
                        begin
                            state_next = gbe_pkg::BE_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = gbe_pkg::BE_IDLE;
            end
        endcase

        owr_next  = owr_reg;
        ord_next  = ord_reg;
        ocnt_next = ocnt_reg;
        if (wr_en)
        begin
            owr_next = (owr_reg == OPTR_LAST) ? '0 : owr_reg + 1'b1;
        end
        if (rd_en)
        begin
            ord_next = (ord_reg == OPTR_LAST) ? '0 : ord_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gbe_pkg::BE_IDLE;
            active_reg <= 1'b0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            aw_reg     <= '0;
            ah_reg     <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            aw_reg     <= aw_next;
            ah_reg     <= ah_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            owr_reg    <= owr_next;
            ord_reg    <= ord_next;
            ocnt_reg   <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bit_reg  <= bit_next;
        sub_reg  <= sub_next;
        if (wr_en)
        begin
            ofifo_reg[owr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire
